// File: rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority ready queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int COUNT_W     = 5;                    // entry_count field width
    localparam int EXT_W       = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int ID_W        = 8;
    localparam int PRI_W       = 8;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_REM = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_EXEC = 1'b1
    } ctrl_state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;    // latch the accepted request word
        logic exec;    // commit the update and load the result register
    } dp_cmd_t;

endpackage

// File: rtl/spq_ctrl.sv
// ---------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: accepts a request word, runs it, holds the result.
// ---------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    output logic    m_tvalid,
    input  logic    m_tready,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_tready;
        s_tready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            CS_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                // result register free or draining this cycle
                if (!m_valid_reg || m_tready)
                begin
                    cmd.exec     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

    // a word is never committed over a result not yet taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    // a held result stays until taken
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |=> m_valid_reg)
        else $error("pending result dropped");

    // every accepted word is executed next or held in EXEC
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == CS_EXEC && !s_tready))
        else $error("accepted word not executed");

endmodule

// File: rtl/spq_datapath.sv
// ---------------------------------------------------------------------------
// spq_datapath
// Sorted slot array; every slot compares and shifts in parallel.
// ---------------------------------------------------------------------------
module spq_datapath
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic [23:0] m_tdata,
    output logic [1:0]  m_tuser
);

    logic [ID_W-1:0]  slot_id_reg  [QUEUE_DEPTH];
    logic [PRI_W-1:0] slot_pri_reg [QUEUE_DEPTH];
    logic [ID_W-1:0]  slot_id_next [QUEUE_DEPTH];
    logic [PRI_W-1:0] slot_pri_next[QUEUE_DEPTH];
    logic [CNT_W-1:0] occ_reg, occ_next;

    op_t              req_op_reg;
    logic [ID_W-1:0]  req_id_reg;
    logic [PRI_W-1:0] req_pri_reg;

    status_t          res_stat_reg, res_stat_next;
    logic [ID_W-1:0]  res_id_reg, res_id_next;
    logic [PRI_W-1:0] res_pri_reg, res_pri_next;
    logic [CNT_W-1:0] res_cnt_reg;

    logic [QUEUE_DEPTH-1:0] live, ge, ge_prev, hit, first_hit, shift_fwd;
    logic [PRI_W-1:0]       hit_pri;
    logic                   seen;
    logic                   full, empty, found;
    logic [EXT_W-1:0]       cnt_ext;

    assign full  = (occ_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (occ_reg == '0);

    // per-slot compares
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            live[i] = CNT_W'(i) < occ_reg;
            ge[i]   = live[i] && (slot_pri_reg[i] >= req_pri_reg);
            hit[i]  = live[i] && (slot_id_reg[i] == req_id_reg);
        end
        ge_prev[0] = 1'b1;
        for (int i = 1; i < QUEUE_DEPTH; i++)
            ge_prev[i] = ge[i-1];
    end

    // first match from the head; slots at and after it move forward
    always_comb
    begin
        seen    = 1'b0;
        hit_pri = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            first_hit[i] = hit[i] && !seen;
            seen         = seen | hit[i];
            shift_fwd[i] = seen;
            hit_pri      = hit_pri | ({PRI_W{first_hit[i]}} & slot_pri_reg[i]);
        end
        found = seen;
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            slot_id_next[i]  = slot_id_reg[i];
            slot_pri_next[i] = slot_pri_reg[i];
        end
        occ_next      = occ_reg;
        res_stat_next = STAT_OK;
        res_id_next   = '0;
        res_pri_next  = '0;
        case (req_op_reg)
            OP_ENQ:
            begin
                if (full)
                    res_stat_next = STAT_FULL;
                else
                begin
                    // insert after every entry of greater or equal priority
                    for (int i = 0; i < QUEUE_DEPTH; i++)
                    begin
                        if (!ge[i] && ge_prev[i])
                        begin
                            slot_id_next[i]  = req_id_reg;
                            slot_pri_next[i] = req_pri_reg;
                        end
                    end
                    for (int i = 1; i < QUEUE_DEPTH; i++)
                    begin
                        if (!ge[i] && !ge_prev[i])
                        begin
                            slot_id_next[i]  = slot_id_reg[i-1];
                            slot_pri_next[i] = slot_pri_reg[i-1];
                        end
                    end
                    occ_next     = occ_reg + 1'b1;
                    res_id_next  = req_id_reg;
                    res_pri_next = req_pri_reg;
                end
            end
            OP_DEQ:
            begin
                if (empty)
                    res_stat_next = STAT_EMPTY;
                else
                begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        slot_id_next[i]  = slot_id_reg[i+1];
                        slot_pri_next[i] = slot_pri_reg[i+1];
                    end
                    occ_next     = occ_reg - 1'b1;
                    res_id_next  = slot_id_reg[0];
                    res_pri_next = slot_pri_reg[0];
                end
            end
            OP_REM:
            begin
                if (!found)
                    res_stat_next = STAT_NOT_FOUND;
                else
                begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                    begin
                        if (shift_fwd[i])
                        begin
                            slot_id_next[i]  = slot_id_reg[i+1];
                            slot_pri_next[i] = slot_pri_reg[i+1];
                        end
                    end
                    occ_next     = occ_reg - 1'b1;
                    res_id_next  = req_id_reg;
                    res_pri_next = hit_pri;
                end
            end
            default:
            begin
                res_stat_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (cmd.exec)
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_op_reg  <= op_t'(s_tuser);
            req_id_reg  <= s_tdata[7:0];
            req_pri_reg <= s_tdata[15:8];
        end
        if (cmd.exec)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                slot_id_reg[i]  <= slot_id_next[i];
                slot_pri_reg[i] <= slot_pri_next[i];
            end
            res_stat_reg <= res_stat_next;
            res_id_reg   <= res_id_next;
            res_pri_reg  <= res_pri_next;
            res_cnt_reg  <= occ_next;
        end
    end

    assign cnt_ext = EXT_W'(res_cnt_reg);
    assign m_tdata = {3'b000, cnt_ext[COUNT_W-1:0], res_pri_reg, res_id_reg};
    assign m_tuser = res_stat_reg;

    // the count never passes the store depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");

endmodule

// File: rtl/stable_priority_ready_queue.sv
// An accepted word is latched and moves to EXEC, which commits it and registers its
//   result once the result register is free or draining; a new word is taken only in
//   IDLE. All slots compare and shift in parallel, so depth does not slow a word.
// A new word is taken while the previous result still waits on the master side.
// Reset (rst_n low, asynchronous): queue empty, no result pending; slot contents
//   are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// stable_priority_ready_queue
// Priority queue of process ids, highest priority first, FIFO among equals.
// Operations: enqueue, dequeue head, remove by id. One result word each.
// ---------------------------------------------------------------------------
module stable_priority_ready_queue
    import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] proc_id, [15:8] priority_req
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_id, [15:8] out_priority,
                                   // [20:16] entry_count, [23:21] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    dp_cmd_t cmd;

    // controller: IDLE takes a word, EXEC commits it once the result slot is free
    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // datapath: request latch, sorted slot array, occupancy, result register
    spq_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule
